// ===== rtl/core/rtc_cal_pkg.sv =====
// Shared types, constants and calendar functions for the calendar clock.
package rtc_cal_pkg;

	// Item kinds carried in the input tuser.
	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_SET  = 2'd1,
		MODE_READ = 2'd2
	} mode_t;

	// Time snapshot handed from the state update to the date pipeline.
	typedef struct packed {
		logic        status;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} snap_t;

	// Full result word.
	typedef struct packed {
		snap_t      snap;
		logic [2:0] weekday;
		logic [8:0] yday;
	} res_t;

	localparam logic [15:0] TPS_RESET    = 16'd1000;
	localparam logic [13:0] YEAR_RESET   = 14'd1970;
	localparam logic [13:0] YEAR_MIN     = 14'd1000;
	localparam logic [13:0] YEAR_SET_MAX = 14'd9999;
	localparam logic [13:0] YEAR_LIMIT   = 14'd16383;
	localparam logic [3:0]  MONTH_MAX    = 4'd12;
	localparam logic [3:0]  MONTH_FEB    = 4'd2;
	localparam logic [4:0]  DAY_LAST_DEC = 5'd31;
	localparam logic [4:0]  HOUR_MAX     = 5'd23;
	localparam logic [5:0]  MINUTE_MAX   = 6'd59;
	localparam logic [5:0]  SECOND_MAX   = 6'd59;
	localparam logic [8:0]  YDAY_MAX     = 9'd365;
	localparam logic [3:0]  WEEK_LEN     = 4'd7;

	// floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for x below 43699.
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

	// Divisibility by 25: x * inverse(25) mod 2^14 stays at or below 655.
	localparam logic [13:0] INV25        = 14'd7209;
	localparam logic [13:0] DIV25_LIM    = 14'd655;

	function automatic logic is_leap(input logic [13:0] y);
		logic [27:0] prod;
		logic        div25;
		prod  = 28'(y) * 28'(INV25);
		div25 = (prod[13:0] <= DIV25_LIM);
		// divisible by 25: leap only when divisible by 400, i.e. also by 16
		return div25 ? (y[3:0] == 4'd0) : (y[1:0] == 2'd0);
	endfunction

	function automatic logic [4:0] month_len(input logic [13:0] y, input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = is_leap(y) ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in a common year before the first of month m.
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/core/rtc_calendar_clock.sv =====
// Top level of the Gregorian calendar clock with tick, set and read words.
//
//  channel  dir  handshake         payload
//  s_*      in   s_tvalid/tready   tuser = mode, tdata = time to set
//  m_*      out  m_tvalid/tready   tuser = status, tdata = time, weekday, day of year
//  cfg_*    in   cfg_wen           cfg_wdata = ticks per second
//
// One word is taken every cycle unless a set or read waits on a full date pipeline;
// the calendar state updates at the edge that retires a word from the input register,
// so back-to-back words chain correctly. A result passes the input register, then the
// date pipeline (snapshot, divide-by-100 multiply, weekday sum, mod 7 output reg),
// before it is on m_*.
// Reset sets 1970-01-01 00:00:00, a zero tick count and 1000 ticks per second.
// Under m_tready low the empty stages fill and then hold; a tick in the input register
// retires without waiting on the output, but queues behind a stalled set or read.
module rtc_calendar_clock (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,   // ticks_per_second
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,     // [1:0] mode
	input  logic [39:0] s_tdata,     // set_year, set_month, set_day, set_hour,
	                                 // set_minute, set_second
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [0:0]  m_tuser,     // [0] status
	output logic [55:0] m_tdata      // now_year, now_month, now_day, now_hour,
	                                 // now_minute, now_second, weekday,
	                                 // day_of_year, zero pad
);
	import rtc_cal_pkg::*;

	// configuration
	logic [15:0] tps_q;

	// input register
	logic        valid_s1;
	mode_t       mode_s1;
	logic [13:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1, hour_s1;
	logic [5:0]  minute_s1, second_s1;

	// calendar state
	logic [15:0] sub_q, sub_n;
	logic [13:0] year_q, year_n;
	logic [3:0]  month_q, month_n;
	logic [4:0]  day_q, day_n, hour_q, hour_n;
	logic [5:0]  minute_q, minute_n, second_q, second_n;

	logic [16:0] tick_nxt;
	logic        tick_roll, at_end, set_ok, emits, fire_s1;
	logic        dc_ready, dc_valid;
	snap_t       snap_c;
	res_t        dc_res;

	// a tick word retires without waiting; set and read need the pipeline
	assign emits    = (mode_s1 == MODE_SET) || (mode_s1 == MODE_READ);
	assign fire_s1  = valid_s1 && (!emits || dc_ready);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_wen) begin
			tps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1   <= mode_t'(s_tuser);
			year_s1   <= s_tdata[13:0];
			month_s1  <= s_tdata[17:14];
			day_s1    <= s_tdata[22:18];
			hour_s1   <= s_tdata[27:23];
			minute_s1 <= s_tdata[33:28];
			second_s1 <= s_tdata[39:34];
		end
	end

	// Next state. A zero ticks-per-second still rolls on every tick because
	// the incremented count is at least one.
	always_comb begin
		sub_n    = sub_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;

		tick_nxt  = 17'(sub_q) + 17'd1;
		tick_roll = (tick_nxt >= 17'(tps_q));
		at_end    = (year_q == YEAR_LIMIT) && (month_q == MONTH_MAX)
		         && (day_q == DAY_LAST_DEC) && (hour_q == HOUR_MAX)
		         && (minute_q == MINUTE_MAX) && (second_q == SECOND_MAX);
		set_ok    = (year_s1 >= YEAR_MIN) && (year_s1 <= YEAR_SET_MAX)
		         && (month_s1 >= 4'd1) && (month_s1 <= MONTH_MAX)
		         && (day_s1 >= 5'd1) && (day_s1 <= month_len(year_s1, month_s1))
		         && (hour_s1 <= HOUR_MAX) && (minute_s1 <= MINUTE_MAX)
		         && (second_s1 <= SECOND_MAX);

		if (fire_s1) begin
			unique case (mode_s1)
				MODE_TICK: begin
					if (!tick_roll) begin
						sub_n = tick_nxt[15:0];
					end else begin
						sub_n = '0;
						// hold at the last second of the range
						if (at_end) begin
						end else if (second_q < SECOND_MAX) begin
							second_n = second_q + 6'd1;
						end else if (minute_q < MINUTE_MAX) begin
							second_n = '0;
							minute_n = minute_q + 6'd1;
						end else if (hour_q < HOUR_MAX) begin
							second_n = '0;
							minute_n = '0;
							hour_n   = hour_q + 5'd1;
						end else begin
							second_n = '0;
							minute_n = '0;
							hour_n   = '0;
							if (day_q < month_len(year_q, month_q)) begin
								day_n = day_q + 5'd1;
							end else if (month_q < MONTH_MAX) begin
								day_n   = 5'd1;
								month_n = month_q + 4'd1;
							end else begin
								day_n   = 5'd1;
								month_n = 4'd1;
								year_n  = year_q + 14'd1;
							end
						end
					end
				end
				MODE_SET: begin
					if (set_ok) begin
						sub_n    = '0;
						year_n   = year_s1;
						month_n  = month_s1;
						day_n    = day_s1;
						hour_n   = hour_s1;
						minute_n = minute_s1;
						second_n = second_s1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q    <= '0;
			year_q   <= YEAR_RESET;
			month_q  <= 4'd1;
			day_q    <= 5'd1;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else begin
			sub_q    <= sub_n;
			year_q   <= year_n;
			month_q  <= month_n;
			day_q    <= day_n;
			hour_q   <= hour_n;
			minute_q <= minute_n;
			second_q <= second_n;
		end
	end

	// report the time after the word, with status only for a rejected set
	always_comb begin
		snap_c.status = (mode_s1 == MODE_SET) && !set_ok;
		snap_c.year   = year_n;
		snap_c.month  = month_n;
		snap_c.day    = day_n;
		snap_c.hour   = hour_n;
		snap_c.minute = minute_n;
		snap_c.second = second_n;
	end

	rtc_cal_datecalc u_datecalc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1 && emits),
		.in_ready  (dc_ready),
		.in_snap   (snap_c),
		.out_valid (dc_valid),
		.out_ready (m_tready),
		.out_res   (dc_res)
	);

	assign m_tvalid = dc_valid;
	assign m_tuser  = dc_res.snap.status;
	assign m_tdata  = {4'd0, dc_res.yday, dc_res.weekday, dc_res.snap.second,
	                   dc_res.snap.minute, dc_res.snap.hour, dc_res.snap.day,
	                   dc_res.snap.month, dc_res.snap.year};

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(month_q >= 4'd1) && (month_q <= MONTH_MAX))
		else $error("month left its range");

	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		(day_q >= 5'd1) && (day_q <= month_len(year_q, month_q)))
		else $error("day beyond month length");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hour_q <= HOUR_MAX) && (minute_q <= MINUTE_MAX) && (second_q <= SECOND_MAX)
		&& (year_q >= YEAR_MIN))
		else $error("time of day out of range");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && (mode_s1 == MODE_SET) && !set_ok) |=>
		($stable(year_q) && $stable(month_q) && $stable(day_q) && $stable(hour_q)
		 && $stable(minute_q) && $stable(second_q) && $stable(sub_q)))
		else $error("rejected set changed the clock");

endmodule

// ===== rtl/core/rtc_cal_datecalc.sv =====
// Date pipeline: derives day of year and weekday from a time snapshot.
module rtc_cal_datecalc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rtc_cal_pkg::snap_t  in_snap,
	output logic                out_valid,
	input  logic                out_ready,
	output rtc_cal_pkg::res_t   out_res
);
	import rtc_cal_pkg::*;

	logic        valid_s2, valid_s3, valid_s4, out_valid_q;
	logic        rdy_s2, rdy_s3, rdy_s4, rdy_out;
	snap_t       snap_s2, snap_s3, snap_s4;
	logic [7:0]  q100_s3;
	logic [11:0] p4_s3;
	logic [8:0]  yday_s3, yday_s4;
	logic [14:0] total_s4;
	res_t        res_q;

	logic [13:0] p_c;
	logic [26:0] prod_c;
	logic [8:0]  yday_c;
	logic [14:0] total_c;
	logic [5:0]  dsum_c;
	logic [3:0]  fold_c;
	logic [2:0]  wday_c;

	// each stage moves when the one after it has room
	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy_s4   = !valid_s4 || rdy_out;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_comb begin
		p_c    = snap_s2.year - 14'd1;
		prod_c = 27'(p_c) * 27'(DIV100_MUL);
		yday_c = days_before(snap_s2.month) + 9'(snap_s2.day) - 9'd1
		       + 9'(is_leap(snap_s2.year) && (snap_s2.month > MONTH_FEB));
	end

	// weekday of Jan 1 plus day of year, before the mod 7
	assign total_c = 15'(snap_s3.year) + 15'(q100_s3[7:2]) + 15'(p4_s3)
	               - 15'(q100_s3) + 15'(yday_s3);

	// 8 = 1 mod 7: fold octal digits, then one conditional subtract
	always_comb begin
		dsum_c = 6'(total_s4[2:0]) + 6'(total_s4[5:3]) + 6'(total_s4[8:6])
		       + 6'(total_s4[11:9]) + 6'(total_s4[14:12]);
		fold_c = 4'(dsum_c[2:0]) + 4'(dsum_c[5:3]);
		wday_c = (fold_c >= WEEK_LEN) ? 3'(fold_c - WEEK_LEN) : fold_c[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s2)  valid_s2    <= in_valid;
			if (rdy_s3)  valid_s3    <= valid_s2;
			if (rdy_s4)  valid_s4    <= valid_s3;
			if (rdy_out) out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			snap_s2 <= in_snap;
		end
		if (rdy_s3 && valid_s2) begin
			snap_s3 <= snap_s2;
			q100_s3 <= prod_c[26:DIV100_SHIFT];
			p4_s3   <= p_c[13:2];
			yday_s3 <= yday_c;
		end
		if (rdy_s4 && valid_s3) begin
			snap_s4  <= snap_s3;
			yday_s4  <= yday_s3;
			total_s4 <= total_c;
		end
		if (rdy_out && valid_s4) begin
			res_q.snap    <= snap_s4;
			res_q.weekday <= wday_c;
			res_q.yday    <= yday_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.weekday < 3'd7))
		else $error("weekday out of range");

	a_yday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.yday <= YDAY_MAX))
		else $error("day of year out of range");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !rdy_out) |=> (valid_s4 && $stable(total_s4) && $stable(yday_s4)))
		else $error("stalled stage 4 lost its word");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the calendar clock: drives tick, set and read words against a predictor.
module tb_top;
	import rtc_cal_pkg::*;

	// Mode 3 is not in the package enum; the block must swallow it silently.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Cycles to let the pipeline drain after the last result before a rate write.
	localparam int SETTLE_CYCLES = 12;
	// Hard stop; the slowest legal run stays far below this.
	localparam int LIMIT_CYCLES = 300000;
	// Stop queuing random words once this many live words are queued.
	localparam int WORD_TARGET = 1150;
	localparam int PHASE_WORDS = 140;

	// Output ready patterns.
	typedef enum int {
		RDY_OPEN,
		RDY_RANDOM,
		RDY_COMB,
		RDY_SPARSE
	} ready_style_t;

	// One input word, fields in the order they are packed into s_tdata.
	typedef struct {
		logic [1:0]  kind;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;      // [1:0] mode
	logic [39:0] s_tdata = '0;      // set_year, set_month, set_day, set_hour,
	                                // set_minute, set_second
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [0:0]  m_tuser;           // [0] status
	logic [55:0] m_tdata;           // now_year, now_month, now_day, now_hour,
	                                // now_minute, now_second, weekday,
	                                // day_of_year, zero pad

	rtc_calendar_clock dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	// Words waiting to be driven, and predicted result words waiting to arrive.
	word_t pending_words[$];
	res_t  due_times[$];

	// Predicted calendar state and tick rate.
	int clk_year = 1970;
	int clk_month = 1;
	int clk_day = 1;
	int clk_hour = 0;
	int clk_min = 0;
	int clk_sec = 0;
	int sub_ticks = 0;
	int tick_rate = 1000;

	// Rate the stimulus was generated for (sizes the tick runs).
	int queued_rate = 1000;

	int mismatches = 0;
	int words_queued = 0;
	int n_ticks = 0;
	int n_sets = 0;
	int n_reads = 0;
	int n_checked = 0;
	int rate_writes = 0;
	int cycle_count = 0;

	logic word_taken = 1'b0;
	int   burst_left = 1;
	int   gap_left = 0;
	ready_style_t ready_style = RDY_OPEN;
	int   style_left = 0;
	int   ready_phase = 0;

	// ---------------------------------------------------------------
	// Calendar predictor
	// ---------------------------------------------------------------
	function automatic bit leap_year(input int y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int days_in(input int y, input int m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Carry one second through the calendar; freeze at the last second of the range.
	function automatic void advance_one_second();
		if (clk_year >= YEAR_LIMIT && clk_month == 12 && clk_day == 31 &&
		    clk_hour == 23 && clk_min == 59 && clk_sec == 59)
			return;
		if (clk_sec < 59) begin
			clk_sec++;
			return;
		end
		clk_sec = 0;
		if (clk_min < 59) begin
			clk_min++;
			return;
		end
		clk_min = 0;
		if (clk_hour < 23) begin
			clk_hour++;
			return;
		end
		clk_hour = 0;
		if (clk_day < days_in(clk_year, clk_month)) begin
			clk_day++;
		end else if (clk_month < 12) begin
			clk_day = 1;
			clk_month++;
		end else begin
			clk_day = 1;
			clk_month = 1;
			clk_year++;
		end
	endfunction

	// Build the result word for the current time: weekday from the Jan 1 offset.
	function automatic res_t stamp_now(input logic status);
		res_t r;
		int   yday;
		int   p;
		int   jan1;
		yday = clk_day - 1;
		for (int m = 1; m < clk_month; m++)
			yday += days_in(clk_year, m);
		p = clk_year - 1;
		jan1 = (clk_year + p / 400 + p / 4 - p / 100) % 7;
		r.snap.status = status;
		r.snap.year   = clk_year[13:0];
		r.snap.month  = clk_month[3:0];
		r.snap.day    = clk_day[4:0];
		r.snap.hour   = clk_hour[4:0];
		r.snap.minute = clk_min[5:0];
		r.snap.second = clk_sec[5:0];
		r.weekday     = 3'((jan1 + yday) % 7);
		r.yday        = yday[8:0];
		return r;
	endfunction

	// Apply one accepted word to the predicted state and queue its result, if any.
	function automatic void apply_word(input logic [1:0] kind, input logic [39:0] data);
		int  y;
		int  mo;
		int  d;
		int  h;
		int  mi;
		int  s;
		bit  ok;
		y  = data[13:0];
		mo = data[17:14];
		d  = data[22:18];
		h  = data[27:23];
		mi = data[33:28];
		s  = data[39:34];
		if (kind == MODE_TICK) begin
			n_ticks++;
			// a zero rate behaves as one, and a lowered rate fires on the next tick
			if (sub_ticks + 1 >= tick_rate) begin
				sub_ticks = 0;
				advance_one_second();
			end else begin
				sub_ticks = sub_ticks + 1;
			end
		end else if (kind == MODE_SET) begin
			n_sets++;
			ok = (y >= 1000) && (y <= 9999) && (mo >= 1) && (mo <= 12) &&
			     (d >= 1) && (d <= days_in(y, mo)) && (h <= 23) && (mi <= 59) && (s <= 59);
			if (ok) begin
				clk_year  = y;
				clk_month = mo;
				clk_day   = d;
				clk_hour  = h;
				clk_min   = mi;
				clk_sec   = s;
				sub_ticks = 0;
			end
			due_times.push_back(stamp_now(!ok));
		end else if (kind == MODE_READ) begin
			n_reads++;
			due_times.push_back(stamp_now(1'b0));
		end
	endfunction

	// ---------------------------------------------------------------
	// Mismatch reporting
	// ---------------------------------------------------------------
	task automatic note_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch at result %0d: %s got %0d, expected %0d",
		         n_checked, what, got, want);
	endtask

	// ---------------------------------------------------------------
	// Driver: pop words from the queue, hold each until accepted,
	// and insert random gaps between bursts.
	// ---------------------------------------------------------------
	always @(negedge clk) begin : drive_words
		word_t w;
		if (arst_n && (!s_tvalid || word_taken)) begin
			if (gap_left > 0 || pending_words.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				s_tvalid <= 1'b0;
			end else begin
				w = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= w.kind;
				s_tdata  <= {w.second, w.minute, w.hour, w.day, w.month, w.year};
				if (burst_left <= 1) begin
					// new burst; one burst in four runs with no gap at all
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Receiver: pick a new ready pattern whenever the current one has run its random length.
	always @(negedge clk) begin : drive_ready
		if (style_left == 0) begin
			ready_style = ready_style_t'($urandom_range(0, 3));
			style_left  = $urandom_range(32, 256);
		end else begin
			style_left--;
		end
		ready_phase++;
		case (ready_style)
			RDY_OPEN:   m_tready <= 1'b1;
			RDY_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
			RDY_COMB:   m_tready <= ((ready_phase % 12) < 4);
			default:    m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// ---------------------------------------------------------------
	// Monitor: track rate writes, predict accepted words, check results.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		res_t want;
		word_taken <= s_tvalid && s_tready;
		if (cfg_wen)
			tick_rate = cfg_wdata;
		if (s_tvalid && s_tready)
			apply_word(s_tuser, s_tdata);
		if (m_tvalid && m_tready) begin
			if (due_times.size() == 0) begin
				note_mismatch("result word with nothing expected", 1, 0);
			end else begin
				want = due_times.pop_front();
				if (m_tuser[0] !== want.snap.status)
					note_mismatch("status", m_tuser[0], want.snap.status);
				if (m_tdata[13:0] !== want.snap.year)
					note_mismatch("year", m_tdata[13:0], want.snap.year);
				if (m_tdata[17:14] !== want.snap.month)
					note_mismatch("month", m_tdata[17:14], want.snap.month);
				if (m_tdata[22:18] !== want.snap.day)
					note_mismatch("day", m_tdata[22:18], want.snap.day);
				if (m_tdata[27:23] !== want.snap.hour)
					note_mismatch("hour", m_tdata[27:23], want.snap.hour);
				if (m_tdata[33:28] !== want.snap.minute)
					note_mismatch("minute", m_tdata[33:28], want.snap.minute);
				if (m_tdata[39:34] !== want.snap.second)
					note_mismatch("second", m_tdata[39:34], want.snap.second);
				if (m_tdata[42:40] !== want.weekday)
					note_mismatch("weekday", m_tdata[42:40], want.weekday);
				if (m_tdata[51:43] !== want.yday)
					note_mismatch("day of year", m_tdata[51:43], want.yday);
				if (m_tdata[55:52] !== 4'd0)
					note_mismatch("pad bits", m_tdata[55:52], 0);
				n_checked++;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
			         cycle_count, due_times.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic void push_word(input logic [1:0] kind, input int y, input int mo,
	                                  input int d, input int h, input int mi, input int s);
		word_t w;
		w.kind   = kind;
		w.year   = y[13:0];
		w.month  = mo[3:0];
		w.day    = d[4:0];
		w.hour   = h[4:0];
		w.minute = mi[5:0];
		w.second = s[5:0];
		pending_words.push_back(w);
		if (kind != MODE_UNUSED)
			words_queued++;
	endfunction

	// Word of the given kind with random payload, which the block must ignore for tick, read and unused words.
	function automatic void push_plain(input logic [1:0] kind);
		push_word(kind, $urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
		          $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
	endfunction

	// Wait until every word is in and every result is out, then let the pipeline drain.
	task automatic settle();
		while (pending_words.size() != 0 || s_tvalid || due_times.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_rate(input int v);
		settle();
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v[15:0];
		@(negedge clk);
		cfg_wen   <= 1'b0;
		queued_rate = v;
		rate_writes++;
	endtask

	// One random scenario: mostly a valid set near a carry boundary followed by
	// tick runs and reads, the rest random sets, unused words and lone reads.
	function automatic void queue_scenario();
		int kind;
		int y;
		int mo;
		int d;
		int h;
		int mi;
		int s;
		int runs;
		int run_max;
		kind = $urandom_range(0, 9);
		run_max = (queued_rate == 0) ? 4 : queued_rate * 2 + 2;
		if (run_max > 40)
			run_max = 40;
		if (kind <= 5) begin
			case ($urandom_range(0, 5))
				0:       y = $urandom_range(1000, 9999);
				1:       y = 100 * $urandom_range(10, 99);
				2:       y = 4 * $urandom_range(250, 2499);
				3:       y = 9999;
				4:       y = 1000;
				default: y = 400 * $urandom_range(3, 24);
			endcase
			mo = $urandom_range(0, 2) == 0 ? $urandom_range(1, 12) :
			     ($urandom_range(0, 1) ? 12 : 2);
			d  = $urandom_range(0, 1) ? days_in(y, mo) : $urandom_range(1, days_in(y, mo));
			h  = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
			mi = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
			s  = $urandom_range(0, 1) ? $urandom_range(50, 59) : $urandom_range(0, 59);
			push_word(MODE_SET, y, mo, d, h, mi, s);
			runs = $urandom_range(1, 4);
			repeat (runs) begin
				repeat ($urandom_range(1, run_max))
					push_plain(MODE_TICK);
				push_plain(MODE_READ);
			end
		end else if (kind <= 7) begin
			push_plain(MODE_SET);
			push_plain(MODE_READ);
		end else if (kind == 8) begin
			repeat ($urandom_range(1, 3))
				push_plain(MODE_UNUSED);
			repeat ($urandom_range(1, 5))
				push_plain(MODE_TICK);
			push_plain(MODE_READ);
		end else begin
			push_plain(MODE_READ);
		end
	endfunction

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin : run_test
		int phase_end;
		int p;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset rate: reset time, field extremes,
		// every reject reason and the leap-day rules.
		push_plain(MODE_READ);
		push_plain(MODE_TICK);
		push_plain(MODE_TICK);
		push_word(MODE_SET, 0, 0, 0, 0, 0, 0);
		push_word(MODE_SET, 16383, 15, 31, 31, 63, 63);
		push_word(MODE_SET, 1000, 1, 1, 0, 0, 0);
		push_plain(MODE_READ);
		push_word(MODE_SET, 9999, 12, 31, 23, 59, 59);
		push_word(MODE_SET, 999, 6, 15, 12, 30, 30);
		push_word(MODE_SET, 10000, 6, 15, 12, 30, 30);
		push_word(MODE_SET, 2020, 0, 15, 12, 30, 30);
		push_word(MODE_SET, 2020, 13, 15, 12, 30, 30);
		push_word(MODE_SET, 2020, 6, 0, 12, 30, 30);
		push_word(MODE_SET, 2021, 4, 31, 12, 30, 30);
		push_word(MODE_SET, 1900, 2, 29, 12, 30, 30);
		push_word(MODE_SET, 2000, 2, 29, 12, 30, 30);
		push_word(MODE_SET, 2023, 2, 29, 12, 30, 30);
		push_word(MODE_SET, 2024, 2, 29, 0, 0, 0);
		push_word(MODE_SET, 2024, 3, 1, 24, 0, 0);
		push_word(MODE_SET, 2024, 3, 1, 0, 60, 0);
		push_word(MODE_SET, 2024, 3, 1, 0, 0, 60);
		push_plain(MODE_UNUSED);
		push_plain(MODE_READ);

		// One tick per second: carry past year 9999 into 10000.
		set_rate(1);
		push_word(MODE_SET, 9999, 12, 31, 23, 59, 58);
		push_plain(MODE_TICK);
		push_plain(MODE_READ);
		push_plain(MODE_TICK);
		push_plain(MODE_READ);
		push_plain(MODE_TICK);
		push_plain(MODE_READ);

		// Top rate, then drop it below the count already reached.
		set_rate(65535);
		push_word(MODE_SET, 2024, 12, 31, 23, 59, 59);
		repeat (30) push_plain(MODE_TICK);
		push_plain(MODE_READ);
		set_rate(7);
		push_plain(MODE_TICK);
		push_plain(MODE_READ);

		// Zero rate counts as one tick per second.
		set_rate(0);
		repeat (8) queue_scenario();

		// Random phases over a spread of rates.
		p = 0;
		while (words_queued < WORD_TARGET) begin
			case (p % 6)
				0:       set_rate(1);
				1:       set_rate(2);
				2:       set_rate(3);
				3:       set_rate($urandom_range(1, 9));
				4:       set_rate($urandom_range(0, 1) ? 65535 : $urandom_range(10, 65535));
				default: set_rate(1);
			endcase
			phase_end = words_queued + PHASE_WORDS;
			while (words_queued < phase_end && words_queued < WORD_TARGET)
				queue_scenario();
			p++;
		end

		settle();

		$display("covered %0d ticks, %0d sets, %0d reads across %0d rate writes",
		         n_ticks, n_sets, n_reads, rate_writes);
		$display("checked %0d result words, %0d field mismatches", n_checked, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
